>>> rtl/bcu_pkg.sv
// Package for the branch and condition unit: action codes, constants,
// the architectural state and result word types, and the CR field mask helper.
// No dependencies.
package bcu_pkg;

   // Action codes carried on the request channel
   localparam logic [3:0] ACT_B         = 4'd0;
   localparam logic [3:0] ACT_BC        = 4'd1;
   localparam logic [3:0] ACT_BCLR      = 4'd2;
   localparam logic [3:0] ACT_BCCTR     = 4'd3;
   localparam logic [3:0] ACT_MCRF      = 4'd4;
   localparam logic [3:0] ACT_MFCR      = 4'd5;
   localparam logic [3:0] ACT_MTCRF     = 4'd6;
   localparam logic [3:0] ACT_MCRXR     = 4'd7;
   localparam logic [3:0] ACT_SET_LINK  = 4'd8;
   localparam logic [3:0] ACT_SET_COUNT = 4'd9;

   localparam logic [31:0] ADDR_ALIGN_MASK = 32'hFFFF_FFFC;
   localparam logic [31:0] XER_TOP_MASK    = 32'hF000_0000;
   localparam logic [3:0]  NIBBLE_MASK     = 4'hF;

   // Program counter, link, count and condition registers
   typedef struct packed {
      logic [31:0] pc;
      logic [31:0] lr;
      logic [31:0] ctr;
      logic [31:0] cr;
   } arch_state_type;

   // One result word
   typedef struct packed {
      logic [31:0] next_address;
      logic        branch_taken;
      logic [31:0] reg_result;
      logic        reg_write;
      logic [4:0]  reg_target;
      logic        xer_clear;
   } result_type;

   // Mask of CR field idx (field 0 holds the most significant nibble)
   function automatic logic [31:0] field_mask(input logic [2:0] idx);
      logic [4:0] sh;
      sh = 5'd28 - {idx, 2'b00};
      return XER_TOP_MASK >> (5'd28 - sh);
   endfunction

endpackage

>>> rtl/bcu_exec.sv
// Execute logic of the branch and condition unit: from one item and the
// current architectural state, the next state and the result word.
// Depends on bcu_pkg.
module bcu_exec (
   input  logic [3:0]              action,
   input  logic [31:0]             instr_word,
   input  logic [31:0]             reg_operand,
   input  logic [3:0]              xer_flags,
   input  bcu_pkg::arch_state_type state_cur,
   output bcu_pkg::arch_state_type state_nxt,
   output bcu_pkg::result_type     result
);

   always_comb begin
      logic [4:0]  bo;
      logic [4:0]  bi;
      logic        lk;
      logic        aa;
      logic [31:0] seq;
      logic [31:0] ctr_dec;
      logic        ctr_ok;
      logic        cond_ok;
      logic        cr_bit;
      logic [31:0] disp26;
      logic [31:0] disp16;
      logic [2:0]  dst;
      logic [2:0]  src;
      logic [31:0] src_shift;
      logic [3:0]  nib;
      logic [31:0] dmask;
      logic [31:0] crm_mask;
      logic [4:0]  dst_sh;

      bo      = instr_word[25:21];
      bi      = instr_word[20:16];
      lk      = instr_word[0];
      aa      = instr_word[1];
      seq     = state_cur.pc + 32'd4;
      ctr_dec = state_cur.ctr - 32'd1;
      cr_bit  = state_cur.cr[5'd31 - bi];
      disp26  = {{6{instr_word[25]}}, instr_word[25:2], 2'b00};
      disp16  = {{16{instr_word[15]}}, instr_word[15:2], 2'b00};
      dst     = instr_word[25:23];
      src     = instr_word[20:18];
      dst_sh  = 5'd28 - {dst, 2'b00};
      dmask   = bcu_pkg::field_mask(dst);

      // BO tests: count test only when BO[2] is clear, condition when BO[4] clear
      ctr_ok  = bo[2] | ((ctr_dec != 32'd0) != bo[1]);
      cond_ok = bo[4] | (cr_bit == bo[3]);

      // mcrf source nibble
      src_shift = state_cur.cr >> (5'd28 - {src, 2'b00});
      nib       = src_shift[3:0];

      // mtcrf field mask from CRM
      crm_mask = '0;
      for (int i = 0; i < 8; i++) begin
         if (instr_word[19 - i]) begin
            crm_mask = crm_mask | bcu_pkg::field_mask(3'(i));
         end
      end

      state_nxt = state_cur;
      result    = '0;
      result.next_address = seq;

      case (action)
         bcu_pkg::ACT_B: begin
            result.next_address = aa ? disp26 : disp26 + state_cur.pc;
            result.branch_taken = 1'b1;
            if (lk) begin
               state_nxt.lr = seq;
            end
         end
         bcu_pkg::ACT_BC: begin
            if (!bo[2]) begin
               state_nxt.ctr = ctr_dec;
            end
            if (ctr_ok && cond_ok) begin
               result.next_address = aa ? disp16 : disp16 + state_cur.pc;
               result.branch_taken = 1'b1;
               if (lk) begin
                  state_nxt.lr = seq;
               end
            end
         end
         bcu_pkg::ACT_BCLR: begin
            if (!bo[2]) begin
               state_nxt.ctr = ctr_dec;
            end
            if (ctr_ok && cond_ok) begin
               result.next_address = state_cur.lr & bcu_pkg::ADDR_ALIGN_MASK;
               result.branch_taken = 1'b1;
               if (lk) begin
                  state_nxt.lr = seq;
               end
            end
         end
         bcu_pkg::ACT_BCCTR: begin
            // condition test only, count register untouched
            if (cond_ok) begin
               result.next_address = state_cur.ctr & bcu_pkg::ADDR_ALIGN_MASK;
               result.branch_taken = 1'b1;
               if (lk) begin
                  state_nxt.lr = seq;
               end
            end
         end
         bcu_pkg::ACT_MCRF: begin
            state_nxt.cr = (state_cur.cr & ~dmask) | ({28'd0, nib} << dst_sh);
         end
         bcu_pkg::ACT_MFCR: begin
            result.reg_result = state_cur.cr;
            result.reg_write  = 1'b1;
            result.reg_target = instr_word[25:21];
         end
         bcu_pkg::ACT_MTCRF: begin
            state_nxt.cr = (state_cur.cr & ~crm_mask) | (reg_operand & crm_mask);
         end
         bcu_pkg::ACT_MCRXR: begin
            // SO, OV, CA land in LT, GT, EQ of the target field
            state_nxt.cr = (state_cur.cr & ~dmask) | ({28'd0, xer_flags} << dst_sh);
            result.xer_clear = 1'b1;
         end
         bcu_pkg::ACT_SET_LINK: begin
            state_nxt.lr = reg_operand;
         end
         bcu_pkg::ACT_SET_COUNT: begin
            state_nxt.ctr = reg_operand;
         end
         default: begin
            // unused codes only advance the program counter
         end
      endcase

      state_nxt.pc = result.next_address;
   end

endmodule

>>> rtl/branch_and_condition_unit.sv
// Top level of the branch and condition unit: input stage, architectural
// registers, result register. Depends on bcu_pkg and bcu_exec.
//
// Usage:
//  - Request channel (req_valid / req_stall) carries one word per
//    instruction: action code, instruction word, GPR operand, XER top nibble.
//  - Response channel (rsp_valid / rsp_stall) returns one word per request:
//    next address, taken flag, mfcr image with write flag and target,
//    and the XER clear flag for mcrxr.
//  - csr_write_en / csr_write_data load the start address; the program
//    counter takes the written value. Write only while the unit is idle.
//  - Pipeline: a word accepted from the request channel sits in the input
//    register and is then written into the result register, which drives
//    its response. Throughput is one word per cycle, back to back, while the
//    receiver does not stall, since the state update of one word is complete
//    at the edge that registers its result.
//  - Reset clears PC, LR, CTR and CR to zero and empties both stages.
//  - When the receiver stalls, the result register holds its word; the
//    input register still takes one more word, then req_stall rises.
module branch_and_condition_unit (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [3:0]  req_action,
   input  logic [31:0] req_instr_word,
   input  logic [31:0] req_reg_operand,
   input  logic [3:0]  req_xer_flags,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_next_address,
   output logic        rsp_branch_taken,
   output logic [31:0] rsp_reg_result,
   output logic        rsp_reg_write,
   output logic [4:0]  rsp_reg_target,
   output logic        rsp_xer_clear,
   // configuration
   input  logic        csr_write_en,
   input  logic [31:0] csr_write_data
);

   logic                    in_valid_ff;
   logic [3:0]              in_action_ff;
   logic [31:0]             in_instr_ff;
   logic [31:0]             in_operand_ff;
   logic [3:0]              in_xer_ff;
   bcu_pkg::arch_state_type state_ff;
   bcu_pkg::arch_state_type state_in;
   logic                    rsp_valid_ff;
   bcu_pkg::result_type     rsp_ff;
   bcu_pkg::result_type     rsp_in;
   logic                    req_accept;
   logic                    exec_fire;

   // handshake: execute when the result slot is free or being drained
   assign exec_fire  = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = in_valid_ff && !exec_fire;
   assign req_accept = req_valid && !req_stall;

   bcu_exec u_exec (
      .action      (in_action_ff),
      .instr_word  (in_instr_ff),
      .reg_operand (in_operand_ff),
      .xer_flags   (in_xer_ff),
      .state_cur   (state_ff),
      .state_nxt   (state_in),
      .result      (rsp_in)
   );

   // control and architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         if (req_accept) begin
            in_valid_ff <= 1'b1;
         end else if (exec_fire) begin
            in_valid_ff <= 1'b0;
         end
         if (exec_fire) begin
            rsp_valid_ff <= 1'b1;
            state_ff     <= state_in;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         // start address write, only while idle: a rule for the user, not enforced here
         if (csr_write_en) begin
            state_ff.pc <= csr_write_data;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_action_ff  <= req_action;
         in_instr_ff   <= req_instr_word;
         in_operand_ff <= req_reg_operand;
         in_xer_ff     <= req_xer_flags;
      end
      if (exec_fire) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_next_address = rsp_ff.next_address;
   assign rsp_branch_taken = rsp_ff.branch_taken;
   assign rsp_reg_result   = rsp_ff.reg_result;
   assign rsp_reg_write    = rsp_ff.reg_write;
   assign rsp_reg_target   = rsp_ff.reg_target;
   assign rsp_xer_clear    = rsp_ff.xer_clear;

   // checks
   a_stall_only_when_blocked: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && rsp_valid_ff && rsp_stall))
      else $error("request stalled while the result slot was free");

   a_fire_sets_valid: assert property (@(posedge clock) disable iff (reset)
      exec_fire |=> rsp_valid_ff)
      else $error("executed word did not show on the response channel");

   a_result_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $countones({rsp_ff.branch_taken, rsp_ff.reg_write,
                                   rsp_ff.xer_clear}) <= 1)
      else $error("more than one result kind flagged");

   a_no_write_no_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.reg_write) |-> (rsp_ff.reg_result == 32'd0 &&
                                               rsp_ff.reg_target == 5'd0))
      else $error("register result present without write flag");

endmodule

>>> dv/testbench.sv
// Self-checking testbench for branch_and_condition_unit: drives instruction words,
// predicts PC, LR, CTR and CR behavior in a local model and checks every response word.
// Depends on bcu_pkg and the branch_and_condition_unit RTL.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   // Unused action codes behave as a plain PC + 4
   localparam logic [3:0] ACT_NOP_FIRST = 4'd10;
   localparam logic [3:0] ACT_NOP_LAST  = 4'd15;

   // BO encodings used by the directed branches
   localparam logic [4:0] BO_DEC_NZ_FALSE = 5'b00000;
   localparam logic [4:0] BO_IF_FALSE     = 5'b00100;
   localparam logic [4:0] BO_IF_TRUE      = 5'b01100;
   localparam logic [4:0] BO_DEC_Z        = 5'b10010;
   localparam logic [4:0] BO_ALWAYS       = 5'b10100;

   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int SETTLE_TICKS = 4;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [3:0]  req_action;
   logic [31:0] req_instr_word;
   logic [31:0] req_reg_operand;
   logic [3:0]  req_xer_flags;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [31:0] rsp_next_address;
   logic        rsp_branch_taken;
   logic [31:0] rsp_reg_result;
   logic        rsp_reg_write;
   logic [4:0]  rsp_reg_target;
   logic        rsp_xer_clear;
   logic        csr_write_en;
   logic [31:0] csr_write_data;

   // Architectural state as this bench expects it
   logic [31:0] model_pc;
   logic [31:0] model_lr;
   logic [31:0] model_ctr;
   logic [31:0] model_cr;

   bcu_pkg::result_type expected_results[$];
   int          error_count;
   int          words_sent;
   int          results_checked;
   int          taken_seen;
   int          start_writes;
   int          cycle_count;
   bit          req_gaps_on;
   bit          rsp_stalls_on;
   int          stall_run;
   int          stall_pick;

   branch_and_condition_unit u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_action       (req_action),
      .req_instr_word   (req_instr_word),
      .req_reg_operand  (req_reg_operand),
      .req_xer_flags    (req_xer_flags),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_next_address (rsp_next_address),
      .rsp_branch_taken (rsp_branch_taken),
      .rsp_reg_result   (rsp_reg_result),
      .rsp_reg_write    (rsp_reg_write),
      .rsp_reg_target   (rsp_reg_target),
      .rsp_xer_clear    (rsp_xer_clear),
      .csr_write_en     (csr_write_en),
      .csr_write_data   (csr_write_data)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // BO/BI test; bc and bclr may decrement CTR on the way
   function automatic logic branch_ok(input logic [4:0] bo, input logic [4:0] bi,
                                      input logic use_count);
      logic count_ok;
      logic cond_ok;
      count_ok = 1'b1;
      if (use_count && !bo[2]) begin
         model_ctr = model_ctr - 32'd1;
         count_ok = (model_ctr != 32'd0) != bo[1];
      end
      cond_ok = bo[4] || (model_cr[31 - bi] == bo[3]);
      return count_ok && cond_ok;
   endfunction

   // Retire one word against the model state, return the response it should produce
   function automatic bcu_pkg::result_type retire_word(input logic [3:0] act,
                                                       input logic [31:0] instr,
                                                       input logic [31:0] opnd,
                                                       input logic [3:0] xer);
      bcu_pkg::result_type r;
      logic [31:0] seq;
      logic        lk;
      logic        aa;
      logic [3:0]  nib;
      int          dst;
      int          src;
      r = '0;
      seq = model_pc + 32'd4;
      r.next_address = seq;
      lk = instr[0];
      aa = instr[1];
      dst = int'(instr[25:23]);
      src = int'(instr[20:18]);
      case (act)
         bcu_pkg::ACT_B: begin
            r.next_address = {{6{instr[25]}}, instr[25:2], 2'b00} + (aa ? 32'd0 : model_pc);
            if (lk) model_lr = seq;
            r.branch_taken = 1'b1;
         end
         bcu_pkg::ACT_BC, bcu_pkg::ACT_BCLR, bcu_pkg::ACT_BCCTR: begin
            if (branch_ok(instr[25:21], instr[20:16], act != bcu_pkg::ACT_BCCTR)) begin
               if (act == bcu_pkg::ACT_BC)
                  r.next_address = {{16{instr[15]}}, instr[15:2], 2'b00} +
                                   (aa ? 32'd0 : model_pc);
               else if (act == bcu_pkg::ACT_BCLR)
                  r.next_address = model_lr & bcu_pkg::ADDR_ALIGN_MASK;
               else
                  r.next_address = model_ctr & bcu_pkg::ADDR_ALIGN_MASK;
               // LR target is read above, before the link update
               if (lk) model_lr = seq;
               r.branch_taken = 1'b1;
            end
         end
         bcu_pkg::ACT_MCRF: begin
            nib = model_cr[31 - 4 * src -: 4];
            model_cr[31 - 4 * dst -: 4] = nib;
         end
         bcu_pkg::ACT_MFCR: begin
            r.reg_result = model_cr;
            r.reg_write  = 1'b1;
            r.reg_target = instr[25:21];
         end
         bcu_pkg::ACT_MTCRF: begin
            for (int i = 0; i < 8; i++)
               if (instr[19 - i]) model_cr[31 - 4 * i -: 4] = opnd[31 - 4 * i -: 4];
         end
         bcu_pkg::ACT_MCRXR: begin
            model_cr[31 - 4 * dst -: 4] = xer;
            r.xer_clear = 1'b1;
         end
         bcu_pkg::ACT_SET_LINK:  model_lr = opnd;
         bcu_pkg::ACT_SET_COUNT: model_ctr = opnd;
         default: ;
      endcase
      model_pc = r.next_address;
      return r;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         error_count++;
         $display("%0t ns: %s mismatch, expected %h actual %h", $time, name, want, got);
      end
   endtask

   // Model update and response check, all sampled at the rising edge
   always @(posedge clock) begin
      bcu_pkg::result_type want;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t ns: timeout after %0d cycles, %0d words still expected",
                  $time, cycle_count, expected_results.size());
         $display("*** FAILED ***");
         $finish;
      end
      if (reset) begin
         model_pc  = 32'd0;
         model_lr  = 32'd0;
         model_ctr = 32'd0;
         model_cr  = 32'd0;
         expected_results.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               error_count++;
               $display("%0t ns: response word with nothing expected, next_address %h",
                        $time, rsp_next_address);
            end else begin
               want = expected_results.pop_front();
               results_checked++;
               if (rsp_branch_taken) taken_seen++;
               check_field("next_address", want.next_address, rsp_next_address);
               check_field("branch_taken", 32'(want.branch_taken), 32'(rsp_branch_taken));
               check_field("reg_result", want.reg_result, rsp_reg_result);
               check_field("reg_write", 32'(want.reg_write), 32'(rsp_reg_write));
               check_field("reg_target", 32'(want.reg_target), 32'(rsp_reg_target));
               check_field("xer_clear", 32'(want.xer_clear), 32'(rsp_xer_clear));
            end
         end
         if (req_valid && !req_stall)
            expected_results.push_back(retire_word(req_action, req_instr_word,
                                                   req_reg_operand, req_xer_flags));
         if (csr_write_en) model_pc = csr_write_data;
      end
   end

   // Receiver stall pattern: free runs, short stalls, a few long ones
   always @(negedge clock) begin
      if (stall_run <= 0) begin
         stall_pick = $urandom_range(0, 99);
         if (!rsp_stalls_on || stall_pick < 45) begin
            rsp_stall = 1'b0;
            stall_run = $urandom_range(1, 20);
         end else if (stall_pick < 92) begin
            rsp_stall = 1'b1;
            stall_run = $urandom_range(1, 3);
         end else begin
            rsp_stall = 1'b1;
            stall_run = $urandom_range(8, 40);
         end
      end
      stall_run--;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (!req_gaps_on || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(6, 20);
   endfunction

   // Present one word at the falling edge and hold it until accepted
   task automatic send_word(input logic [3:0] act, input logic [31:0] instr,
                            input logic [31:0] opnd, input logic [3:0] xer);
      int gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid       = 1'b1;
      req_action      = act;
      req_instr_word  = instr;
      req_reg_operand = opnd;
      req_xer_flags   = xer;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      words_sent++;
   endtask

   // Stop sending and wait until every expected word is back
   task automatic drain_results();
      @(negedge clock);
      req_valid = 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (SETTLE_TICKS) @(posedge clock);
   endtask

   task automatic write_start_address(input logic [31:0] addr);
      drain_results();
      @(negedge clock);
      csr_write_en   = 1'b1;
      csr_write_data = addr;
      @(negedge clock);
      csr_write_en   = 1'b0;
      start_writes++;
   endtask

   // Instruction encoders
   function automatic logic [31:0] bform(input logic [4:0] bo, input logic [4:0] bi,
                                         input logic [15:0] bd, input logic aa,
                                         input logic lk);
      return {6'd16, bo, bi, bd[15:2], aa, lk};
   endfunction

   function automatic logic [31:0] iform(input logic [25:0] li, input logic aa,
                                         input logic lk);
      return {6'd18, li[25:2], aa, lk};
   endfunction

   function automatic logic [31:0] crf_pair(input logic [2:0] dst, input logic [2:0] src);
      return {6'd19, dst, 2'b00, src, 18'd0};
   endfunction

   function automatic logic [31:0] crm_form(input logic [7:0] crm);
      return {6'd31, 5'd0, 1'b0, crm, 12'd0};
   endfunction

   // CTR decrement and test, condition tests, link ordering, target extremes
   task automatic test_branch_rules();
      write_start_address(32'h0000_1000);
      send_word(bcu_pkg::ACT_SET_COUNT, 32'd0, 32'd0, 4'h0);
      send_word(bcu_pkg::ACT_BC, bform(BO_DEC_NZ_FALSE, 5'd0, 16'h0040, 1'b0, 1'b0),
                32'd0, 4'h0);
      send_word(bcu_pkg::ACT_BC, bform(BO_DEC_Z, 5'd0, 16'h8000, 1'b0, 1'b1),
                32'd0, 4'h0);
      send_word(bcu_pkg::ACT_SET_COUNT, 32'd0, 32'd1, 4'h0);
      send_word(bcu_pkg::ACT_BC, bform(BO_DEC_Z, 5'd0, 16'h8000, 1'b0, 1'b1),
                32'd0, 4'h0);
      send_word(bcu_pkg::ACT_BCLR, bform(BO_ALWAYS, 5'd0, 16'h0, 1'b0, 1'b1),
                32'd0, 4'h0);
      send_word(bcu_pkg::ACT_BC, bform(BO_ALWAYS, 5'd0, 16'h7FFC, 1'b1, 1'b0),
                32'd0, 4'h0);
      send_word(bcu_pkg::ACT_BC, bform(BO_IF_TRUE, 5'd3, 16'h0100, 1'b0, 1'b1),
                32'd0, 4'h0);
      send_word(bcu_pkg::ACT_BC, bform(BO_IF_FALSE, 5'd31, 16'hFFFC, 1'b0, 1'b0),
                32'd0, 4'h0);
      send_word(bcu_pkg::ACT_SET_COUNT, 32'd0, 32'hFFFF_FFFF, 4'h0);
      send_word(bcu_pkg::ACT_BCCTR, bform(BO_ALWAYS, 5'd0, 16'h0, 1'b0, 1'b1),
                32'd0, 4'h0);
      send_word(bcu_pkg::ACT_BCCTR, bform(BO_DEC_Z, 5'd0, 16'h0, 1'b0, 1'b0),
                32'd0, 4'h0);
      send_word(bcu_pkg::ACT_B, iform(26'h200_0000, 1'b0, 1'b0), 32'd0, 4'h0);
      send_word(bcu_pkg::ACT_B, iform(26'h1FF_FFFC, 1'b1, 1'b1), 32'd0, 4'h0);
      send_word(bcu_pkg::ACT_SET_LINK, 32'd0, 32'h1234_5677, 4'h0);
      send_word(bcu_pkg::ACT_BCLR, bform(BO_IF_FALSE, 5'd0, 16'h0, 1'b0, 1'b0),
                32'd0, 4'h0);
   endtask

   // Condition register moves and a branch on a moved bit
   task automatic test_cr_moves();
      send_word(bcu_pkg::ACT_MTCRF, crm_form(8'hFF), 32'hA5C3_0F96, 4'h0);
      send_word(bcu_pkg::ACT_MFCR, {6'd31, 5'd31, 21'd0}, 32'd0, 4'h0);
      send_word(bcu_pkg::ACT_MCRF, crf_pair(3'd7, 3'd0), 32'd0, 4'h0);
      send_word(bcu_pkg::ACT_MCRXR, crf_pair(3'd0, 3'd0), 32'd0, 4'hF);
      send_word(bcu_pkg::ACT_MCRXR, crf_pair(3'd5, 3'd0), 32'd0, 4'hA);
      send_word(bcu_pkg::ACT_MTCRF, crm_form(8'h5A), 32'hFFFF_FFFF, 4'h0);
      send_word(bcu_pkg::ACT_MFCR, 32'd0, 32'd0, 4'h0);
      send_word(bcu_pkg::ACT_BC, bform(BO_IF_TRUE, 5'd0, 16'h0020, 1'b0, 1'b0),
                32'd0, 4'h0);
   endtask

   // PC wraps through zero in both directions; unused actions act as PC + 4
   task automatic test_address_wrap();
      write_start_address(32'hFFFF_FFFC);
      send_word(ACT_NOP_LAST, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hF);
      send_word(bcu_pkg::ACT_B, iform(26'h3FF_FFFC, 1'b0, 1'b0), 32'd0, 4'h0);
      send_word(ACT_NOP_FIRST, 32'd0, 32'd0, 4'h0);
   endtask

   // One random word, weighted toward branches; small CTR loads reach the zero test
   task automatic send_random_word();
      int          pick;
      logic [3:0]  act;
      logic [31:0] opnd;
      pick = $urandom_range(0, 99);
      opnd = $urandom();
      if (pick < 8)       act = bcu_pkg::ACT_B;
      else if (pick < 24) act = bcu_pkg::ACT_BC;
      else if (pick < 36) act = bcu_pkg::ACT_BCLR;
      else if (pick < 46) act = bcu_pkg::ACT_BCCTR;
      else if (pick < 54) act = bcu_pkg::ACT_MCRF;
      else if (pick < 64) act = bcu_pkg::ACT_MFCR;
      else if (pick < 74) act = bcu_pkg::ACT_MTCRF;
      else if (pick < 82) act = bcu_pkg::ACT_MCRXR;
      else if (pick < 89) act = bcu_pkg::ACT_SET_LINK;
      else if (pick < 97) act = bcu_pkg::ACT_SET_COUNT;
      else                act = 4'($urandom_range(ACT_NOP_FIRST, ACT_NOP_LAST));
      if (act == bcu_pkg::ACT_SET_COUNT && $urandom_range(0, 1) == 1)
         opnd = $urandom_range(0, 3);
      send_word(act, $urandom(), opnd, 4'($urandom_range(0, 15)));
   endtask

   task automatic test_random_stream(input logic [31:0] start_pc, input int count,
                                     input bit gaps, input bit stalls);
      req_gaps_on   = gaps;
      rsp_stalls_on = stalls;
      write_start_address(start_pc);
      for (int k = 0; k < count; k++) begin
         // mid-stream the sender holds off until the pipe runs dry
         if (k == count / 2) drain_results();
         send_random_word();
      end
   endtask

   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_action      = bcu_pkg::ACT_B;
      req_instr_word  = 32'd0;
      req_reg_operand = 32'd0;
      req_xer_flags   = 4'h0;
      rsp_stall       = 1'b0;
      csr_write_en    = 1'b0;
      csr_write_data  = 32'd0;
      error_count     = 0;
      words_sent      = 0;
      results_checked = 0;
      taken_seen      = 0;
      start_writes    = 0;
      cycle_count     = 0;
      stall_run       = 0;
      req_gaps_on     = 1'b1;
      rsp_stalls_on   = 1'b1;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_branch_rules();
      test_cr_moves();
      test_address_wrap();
      test_random_stream(32'h0000_0000, 325, 1'b1, 1'b1);
      test_random_stream(32'hFFFF_FFFF, 325, 1'b0, 1'b0);
      test_random_stream($urandom(), 325, 1'b1, 1'b0);
      test_random_stream(32'h8000_0000, 325, 1'b0, 1'b1);
      test_random_stream(32'hFFFF_FFFC, 325, 1'b1, 1'b1);

      drain_results();
      repeat (8) @(posedge clock);
      if (expected_results.size() != 0) begin
         error_count++;
         $display("%0t ns: %0d expected words never arrived", $time, expected_results.size());
      end

      $display("Sent %0d words, checked %0d responses (%0d taken branches), %0d start addresses.",
               words_sent, results_checked, taken_seen, start_writes);
      $display("Streams ran with and without sender gaps and receiver stalls, with drained pauses.");
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
